@@ rtl/core/mvt_pkg.sv @@
// Package for the 4x4 matrix-vector transform unit.
// Holds shared widths, the opcode type and the lane control/result structs.
// Depends on nothing; every other file in rtl/core uses it.
package mvt_pkg;

  // Fixed field widths of the datapath.
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 66;
  localparam int MAX_DIM = 4;
  localparam int ROW_W   = 2;

  // Saturation limits of a Q16.16 word.
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Operation carried by an input word.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_t;

  // Pipeline enables shared by all lanes.
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } lane_ctrl_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } lane_res_t;

endpackage

@@ rtl/core/mvt_coeff_store.sv @@
// Coefficient store: a DIM x DIM matrix of Q16.16 words, cleared at reset.
// A load word writes one whole row. Depends on mvt_pkg.
module mvt_coeff_store #(
  parameter int DIM = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [mvt_pkg::ROW_W-1:0]              row_sel,
  input  logic signed [mvt_pkg::DATA_W-1:0]      wr_data [mvt_pkg::MAX_DIM],
  output logic signed [mvt_pkg::DATA_W-1:0]      coeff [mvt_pkg::MAX_DIM][mvt_pkg::MAX_DIM]
);

  logic signed [mvt_pkg::DATA_W-1:0] coeff_r [mvt_pkg::MAX_DIM][mvt_pkg::MAX_DIM];

  // Row write; rows and columns at or beyond DIM stay zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < mvt_pkg::MAX_DIM; r++) begin
        for (int c = 0; c < mvt_pkg::MAX_DIM; c++) begin
          coeff_r[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      for (int r = 0; r < DIM; r++) begin
        if (row_sel == mvt_pkg::ROW_W'(r)) begin
          for (int c = 0; c < DIM; c++) begin
            coeff_r[r][c] <= wr_data[c];
          end
        end
      end
    end
  end

  assign coeff = coeff_r;

endmodule

@@ rtl/core/mvt_lane.sv @@
// One dot-product lane: DIM multipliers, a registered sum, then shift and saturate.
// Depends on mvt_pkg.
module mvt_lane #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  mvt_pkg::lane_ctrl_t               ctrl,
  input  logic signed [mvt_pkg::DATA_W-1:0] coeff [mvt_pkg::MAX_DIM],
  input  logic signed [mvt_pkg::DATA_W-1:0] vec [mvt_pkg::MAX_DIM],
  output mvt_pkg::lane_res_t                res
);

  logic signed [mvt_pkg::PROD_W-1:0] prod_r [DIM];
  logic signed [mvt_pkg::ACC_W-1:0]  sum_nxt;
  logic signed [mvt_pkg::ACC_W-1:0]  sum_r;
  logic signed [mvt_pkg::ACC_W-1:0]  shifted;
  logic                              in_range;

  // Stage one: exact 64-bit products of coefficient and component.
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      for (int c = 0; c < DIM; c++) begin
        prod_r[c] <= mvt_pkg::PROD_W'(coeff[c]) * mvt_pkg::PROD_W'(vec[c]);
      end
    end
  end

  // Stage two: exact sum of the products.
  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < DIM; c++) begin
      sum_nxt = sum_nxt + mvt_pkg::ACC_W'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  // Arithmetic shift back to Q16.16 and clamp to the 32-bit range.
  always_comb begin
    shifted  = sum_r >>> FRAC_BITS;
    in_range = (&shifted[mvt_pkg::ACC_W-1:mvt_pkg::DATA_W-1]) ||
               !(|shifted[mvt_pkg::ACC_W-1:mvt_pkg::DATA_W-1]);
    res.sat  = !in_range;
    if (in_range) begin
      res.value = shifted[mvt_pkg::DATA_W-1:0];
    end else if (sum_r[mvt_pkg::ACC_W-1]) begin
      res.value = mvt_pkg::SAT_MIN;
    end else begin
      res.value = mvt_pkg::SAT_MAX;
    end
  end

endmodule

@@ rtl/core/mvt_merge.sv @@
// Merge stage: registers the four lane results and combines their saturation flags.
// Depends on mvt_pkg.
module mvt_merge (
  input  logic                       clk,
  input  logic                       load_en,
  input  mvt_pkg::lane_res_t         lane_res [mvt_pkg::MAX_DIM],
  output logic [mvt_pkg::DATA_W-1:0] rx,
  output logic [mvt_pkg::DATA_W-1:0] ry,
  output logic [mvt_pkg::DATA_W-1:0] rz,
  output logic [mvt_pkg::DATA_W-1:0] rw,
  output logic                       clipped
);

  logic [mvt_pkg::DATA_W-1:0] rx_r, ry_r, rz_r, rw_r;
  logic                       clipped_r;
  logic                       any_sat;

  // Any lane that clamped marks the whole word.
  always_comb begin
    any_sat = 1'b0;
    for (int r = 0; r < mvt_pkg::MAX_DIM; r++) begin
      any_sat = any_sat | lane_res[r].sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_en) begin
      rx_r      <= lane_res[0].value;
      ry_r      <= lane_res[1].value;
      rz_r      <= lane_res[2].value;
      rw_r      <= lane_res[3].value;
      clipped_r <= any_sat;
    end
  end

  assign rx      = rx_r;
  assign ry      = ry_r;
  assign rz      = rz_r;
  assign rw      = rw_r;
  assign clipped = clipped_r;

endmodule

@@ rtl/core/matrix_vector_transform_4x4.sv @@
// Top level of the vertex transform unit: coefficient store, dot-product lanes, merge.
// Depends on mvt_pkg, mvt_coeff_store, mvt_lane and mvt_merge.
//
// Usage: each input word carries an opcode, a row index and four Q16.16
// components. A load word (opcode 0) writes the components into one matrix
// row and gives no result; a row index at or beyond DIM is ignored. A
// transform word (opcode 1) gives one output word: the four row dot products
// rx..rw, shifted right by FRAC_BITS and clamped to 32 bits, with clipped set
// when any of them clamped. Rows beyond DIM read as zero.
// Throughput: one word per cycle while in_stall is low, loads and transforms mixed
// freely; a transform right after a load already sees the new row.
// A transform word passes the product register, the sum register and the output
// register, in that order, before out_valid shows its result.
// Reset clears the matrix to zero and empties the pipeline.
// When the receiver stalls, the output word holds and the stages behind it
// fill up; in_stall rises once the first stage is full and cannot move.
module matrix_vector_transform_4x4 #(
  parameter int FRAC_BITS = 16,
  parameter int DIM       = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [1:0]  in_row_sel,
  input  logic [31:0] in_c0,
  input  logic [31:0] in_c1,
  input  logic [31:0] in_c2,
  input  logic [31:0] in_c3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rx,
  output logic [31:0] out_ry,
  output logic [31:0] out_rz,
  output logic [31:0] out_rw,
  output logic        out_clipped
);

  logic signed [mvt_pkg::DATA_W-1:0] vec [mvt_pkg::MAX_DIM];
  logic signed [mvt_pkg::DATA_W-1:0] coeff [mvt_pkg::MAX_DIM][mvt_pkg::MAX_DIM];
  mvt_pkg::lane_res_t                lane_res [mvt_pkg::MAX_DIM];
  mvt_pkg::lane_ctrl_t               lane_ctrl;
  mvt_pkg::opcode_t                  opcode;

  logic in_take;
  logic load_take;
  logic xform_take;
  logic prod_v_r, prod_v_nxt;
  logic sum_v_r, sum_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_free, sum_free, prod_free;

  assign opcode = mvt_pkg::opcode_t'(in_opcode);
  assign vec[0] = in_c0;
  assign vec[1] = in_c1;
  assign vec[2] = in_c2;
  assign vec[3] = in_c3;

  // Each stage moves when the one ahead of it is empty or moving.
  assign out_free  = !out_v_r || !out_stall;
  assign sum_free  = !sum_v_r || out_free;
  assign prod_free = !prod_v_r || sum_free;
  assign in_stall  = !prod_free;

  assign in_take    = in_valid && !in_stall;
  assign load_take  = in_take && (opcode == mvt_pkg::OP_LOAD);
  assign xform_take = in_take && (opcode == mvt_pkg::OP_XFORM);

  assign lane_ctrl.prod_en = xform_take;
  assign lane_ctrl.sum_en  = prod_v_r && sum_free;

  // Valid bits of the three stages.
  always_comb begin
    prod_v_nxt = prod_free ? xform_take : prod_v_r;
    sum_v_nxt  = sum_free ? prod_v_r : sum_v_r;
    out_v_nxt  = out_free ? sum_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
      sum_v_r  <= sum_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;

  // Matrix rows.
  mvt_coeff_store #(
    .DIM (DIM)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_take),
    .row_sel (in_row_sel),
    .wr_data (vec),
    .coeff   (coeff)
  );

  // One lane per matrix row; rows beyond DIM give zero and never clamp.
  for (genvar r = 0; r < mvt_pkg::MAX_DIM; r++) begin : g_lane
    if (r < DIM) begin : g_on
      mvt_lane #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk   (clk),
        .ctrl  (lane_ctrl),
        .coeff (coeff[r]),
        .vec   (vec),
        .res   (lane_res[r])
      );
    end else begin : g_off
      assign lane_res[r] = '0;
    end
  end

  // Output word.
  mvt_merge u_merge (
    .clk      (clk),
    .load_en  (sum_v_r && out_free),
    .lane_res (lane_res),
    .rx       (out_rx),
    .ry       (out_ry),
    .rz       (out_rz),
    .rw       (out_rw),
    .clipped  (out_clipped)
  );

endmodule
